@@ rtl/glcc_pkg.sv @@
// Shared types, codes and constants of the grid line collision check unit.
package glcc_pkg;

    // Default grid side, in cells.
    localparam int MaxSideDefault = 256;

    // Width of the shared iterative divider.
    localparam int DW = 36;

    // Last iteration counts of the square and square-root loops.
    localparam int SqLast = 32;
    localparam int RtLast = 33;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_ALLOW_UNK = 3'd1,
        REG_CSTEP     = 3'd2,
        REG_CSIZE     = 3'd3,
        REG_ORIGIN_X  = 3'd4,
        REG_ORIGIN_Y  = 3'd5,
        REG_MWIDTH    = 3'd6,
        REG_MHEIGHT   = 3'd7
    } reg_idx_t;

    // Result status codes.
    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_OUT     = 2'd3;

    // Special cost codes.
    localparam logic signed [7:0] COST_UNKNOWN = -8'sd1;
    localparam logic signed [7:0] COST_OUT     = -8'sd2;

    // Input item modes.
    localparam logic MODE_WRITE = 1'b0;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_LOAD,
        OP_SQ,
        OP_SQ_B_INIT,
        OP_RT_INIT,
        OP_RT,
        OP_DIV_K,
        OP_N1,
        OP_QX,
        OP_QY,
        OP_DIV_X,
        OP_CX,
        OP_CY,
        OP_READ,
        OP_EVAL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sq_last;
        logic rt_last;
        logic div_busy;
        logic final_sample;
    } sts_t;

    typedef struct packed {
        logic [6:0]         threshold;
        logic               allow_unk;
        logic [30:0]        cstep;
        logic [30:0]        csize;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [8:0]         mwidth;
        logic [8:0]         mheight;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [15:0]        cell_index;
        logic signed [7:0]  cell_value;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } item_t;

endpackage

@@ rtl/glcc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module glcc_div #(
    parameter int W = glcc_pkg::DW
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [W-1:0] remd
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    trial;
    logic          fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {r_reg, q_reg[W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    // Control state of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[W-2:0], fits};
            r_reg <= fits ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign remd = r_reg;

endmodule

@@ rtl/glcc_dpath.sv @@
// Datapath: grid memory, line length, sample walk and cell tests.
module glcc_dpath #(
    parameter int MAX_SIDE = glcc_pkg::MaxSideDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  glcc_pkg::cmd_t      cmd,
    input  glcc_pkg::cfg_t      cfg,
    input  glcc_pkg::item_t     item,
    output glcc_pkg::sts_t      sts,
    output logic [1:0]          res_status,
    output logic signed [31:0]  res_x,
    output logic signed [31:0]  res_y,
    output logic signed [7:0]   res_cost
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = glcc_pkg::DW;
    localparam logic [7:0] COST_UNK_BITS = glcc_pkg::COST_UNKNOWN;

    glcc_pkg::op_t op;

    // Grid memory and its clearing counter.
    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          we;
    logic [AW-1:0] raddr;
    logic [7:0]    rd_reg;

    // Line registers.
    logic signed [31:0] sx_reg, sy_reg;
    logic               negx_reg, negy_reg;
    logic [32:0]        magx_reg, magy_reg;
    logic [66:0]        acc_reg, sh_reg;
    logic [32:0]        m_reg;
    logic [5:0]         cnt_reg;
    logic [67:0]        rad_reg;
    logic [34:0]        rem_reg;
    logic [33:0]        root_reg;
    logic [DW-1:0]      n1_reg;
    logic [32:0]        qx_reg, qy_reg;
    logic [DW-1:0]      rmx_reg, rmy_reg;
    logic [32:0]        offx_reg, offy_reg;
    logic [DW:0]        remx_reg, remy_reg;
    logic [DW-1:0]      i_reg;
    logic [SIDE_W-1:0]  cx_reg, cy_reg;
    logic               outx_reg, outy_reg;

    // Derived configuration.
    logic [30:0]       cs;
    logic [30:0]       half;
    logic [30:0]       step_raw;
    logic [30:0]       step;
    logic [SIDE_W-1:0] w, h;

    // Combinational helpers.
    logic signed [32:0] dx, dy;
    logic [32:0]        magx_in, magy_in;
    logic [36:0]        rt_cat, rt_trial;
    logic               rt_fit;
    logic [34:0]        r_ceil;
    logic [DW-1:0]      k;
    logic [DW-1:0]      n1_next;
    logic signed [31:0] wx, wy;
    logic signed [33:0] wx_w, wy_w;
    logic signed [32:0] diffx, diffy;
    logic [DW:0]        remx_sum, remy_sum;
    logic               carx, cary;
    logic [2*SIDE_W:0]  lin;
    logic signed [7:0]  cost;
    logic [1:0]         st;
    logic               last;

    logic          div_start;
    logic [DW-1:0] div_a, div_b, div_q, div_r;
    logic          div_busy;

    assign op = cmd.op;

    // Cell size, step at least half a cell, zero taken as one.
    assign cs       = (cfg.csize == '0) ? 31'd1 : cfg.csize;
    assign half     = cs >> 1;
    assign step_raw = (cfg.cstep > half) ? cfg.cstep : half;
    assign step     = (step_raw == '0) ? 31'd1 : step_raw;
    assign w = (32'(cfg.mwidth) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(cfg.mwidth);
    assign h = (32'(cfg.mheight) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(cfg.mheight);

    // Line deltas and their magnitudes.
    assign dx      = 33'(item.goal_x) - 33'(item.start_x);
    assign dy      = 33'(item.goal_y) - 33'(item.start_y);
    assign magx_in = dx[32] ? 33'(-dx) : 33'(dx);
    assign magy_in = dy[32] ? 33'(-dy) : 33'(dy);

    // One square-root digit step.
    assign rt_cat   = {rem_reg, rad_reg[67:66]};
    assign rt_trial = {1'b0, root_reg, 2'b01};
    assign rt_fit   = rt_cat >= rt_trial;
    assign r_ceil   = 35'(root_reg) + 35'(rem_reg != '0);

    // Sample count from the divider result.
    assign k       = div_q + DW'(div_r != '0);
    assign n1_next = (k == '0) ? DW'(1) : k;

    // Current sample point and its offset from the map corner.
    assign wx_w  = negx_reg ? (34'(sx_reg) - $signed({1'b0, offx_reg}))
                            : (34'(sx_reg) + $signed({1'b0, offx_reg}));
    assign wy_w  = negy_reg ? (34'(sy_reg) - $signed({1'b0, offy_reg}))
                            : (34'(sy_reg) + $signed({1'b0, offy_reg}));
    assign wx    = wx_w[31:0];
    assign wy    = wy_w[31:0];
    assign diffx = 33'(wx) - 33'(cfg.origin_x);
    assign diffy = 33'(wy) - 33'(cfg.origin_y);

    // Offset advance with remainder carry.
    assign remx_sum = remx_reg + (DW + 1)'(rmx_reg);
    assign remy_sum = remy_reg + (DW + 1)'(rmy_reg);
    assign carx     = remx_sum >= (DW + 1)'(n1_reg);
    assign cary     = remy_sum >= (DW + 1)'(n1_reg);

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = DW'(1);
        case (op)
            glcc_pkg::OP_DIV_K: begin
                div_start = 1'b1;
                div_a     = DW'(r_ceil);
                div_b     = DW'(step);
            end
            glcc_pkg::OP_N1: begin
                div_start = 1'b1;
                div_a     = DW'(magx_reg);
                div_b     = n1_next;
            end
            glcc_pkg::OP_QX: begin
                div_start = 1'b1;
                div_a     = DW'(magy_reg);
                div_b     = n1_reg;
            end
            glcc_pkg::OP_DIV_X: begin
                div_start = 1'b1;
                div_a     = DW'(diffx[31:0]);
                div_b     = DW'(cs);
            end
            glcc_pkg::OP_CX: begin
                div_start = 1'b1;
                div_a     = DW'(diffy[31:0]);
                div_b     = DW'(cs);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    glcc_div #(.W(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quot     (div_q),
        .remd     (div_r)
    );

    // Memory write port: clearing pass or cell write.
    assign we    = (op == glcc_pkg::OP_CLEAR) ||
                   ((op == glcc_pkg::OP_WRITE) && (32'(item.cell_index) < 32'(DEPTH)));
    assign waddr = (op == glcc_pkg::OP_CLEAR) ? clr_reg : AW'(32'(item.cell_index));
    assign wdata = (op == glcc_pkg::OP_CLEAR) ? COST_UNK_BITS : item.cell_value;

    // Cell address of the current sample.
    assign lin   = (2 * SIDE_W + 1)'(cy_reg) * (2 * SIDE_W + 1)'(w)
                 + (2 * SIDE_W + 1)'(cx_reg);
    assign raddr = AW'(lin);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (op == glcc_pkg::OP_READ) begin
            rd_reg <= mem[raddr];
        end
    end

    // Clearing pass address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (op == glcc_pkg::OP_CLEAR) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Sample test in the order: out of map, unknown, cost.
    assign cost = rd_reg;
    always_comb begin
        if (outx_reg || outy_reg) begin
            st = glcc_pkg::ST_OUT;
        end else if (cost == glcc_pkg::COST_UNKNOWN && !cfg.allow_unk) begin
            st = glcc_pkg::ST_UNKNOWN;
        end else if (cost >= $signed({1'b0, cfg.threshold})) begin
            st = glcc_pkg::ST_BLOCKED;
        end else begin
            st = glcc_pkg::ST_CLEAR;
        end
    end
    assign last = (i_reg == n1_reg);

    // Line setup, walk and result registers.
    always_ff @(posedge aclk) begin
        case (op)
            glcc_pkg::OP_LOAD: begin
                sx_reg   <= item.start_x;
                sy_reg   <= item.start_y;
                negx_reg <= dx[32];
                negy_reg <= dy[32];
                magx_reg <= magx_in;
                magy_reg <= magy_in;
                acc_reg  <= '0;
                sh_reg   <= 67'(magx_in);
                m_reg    <= magx_in;
                cnt_reg  <= '0;
            end
            glcc_pkg::OP_SQ: begin
                if (m_reg[0]) begin
                    acc_reg <= acc_reg + sh_reg;
                end
                sh_reg  <= sh_reg << 1;
                m_reg   <= m_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            glcc_pkg::OP_SQ_B_INIT: begin
                sh_reg  <= 67'(magy_reg);
                m_reg   <= magy_reg;
                cnt_reg <= '0;
            end
            glcc_pkg::OP_RT_INIT: begin
                rad_reg  <= {1'b0, acc_reg};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            glcc_pkg::OP_RT: begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rt_fit ? 35'(rt_cat - rt_trial) : 35'(rt_cat);
                root_reg <= {root_reg[32:0], rt_fit};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            glcc_pkg::OP_N1: begin
                n1_reg <= n1_next;
            end
            glcc_pkg::OP_QX: begin
                qx_reg  <= div_q[32:0];
                rmx_reg <= div_r;
            end
            glcc_pkg::OP_QY: begin
                qy_reg   <= div_q[32:0];
                rmy_reg  <= div_r;
                offx_reg <= '0;
                offy_reg <= '0;
                remx_reg <= '0;
                remy_reg <= '0;
                i_reg    <= '0;
            end
            glcc_pkg::OP_CX: begin
                cx_reg   <= div_q[SIDE_W-1:0];
                outx_reg <= diffx[32] || (div_q >= DW'(w));
            end
            glcc_pkg::OP_CY: begin
                cy_reg   <= div_q[SIDE_W-1:0];
                outy_reg <= diffy[32] || (div_q >= DW'(h));
            end
            glcc_pkg::OP_EVAL: begin
                if (st != glcc_pkg::ST_CLEAR) begin
                    res_status <= st;
                    res_x      <= wx;
                    res_y      <= wy;
                    res_cost   <= (st == glcc_pkg::ST_OUT) ? glcc_pkg::COST_OUT : cost;
                end else if (last) begin
                    res_status <= glcc_pkg::ST_CLEAR;
                    res_x      <= '0;
                    res_y      <= '0;
                    res_cost   <= '0;
                end else begin
                    i_reg    <= i_reg + DW'(1);
                    offx_reg <= offx_reg + qx_reg + 33'(carx);
                    offy_reg <= offy_reg + qy_reg + 33'(cary);
                    remx_reg <= carx ? remx_sum - (DW + 1)'(n1_reg) : remx_sum;
                    remy_reg <= cary ? remy_sum - (DW + 1)'(n1_reg) : remy_sum;
                end
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller.
    assign sts.clr_last     = (clr_reg == AW'(DEPTH - 1));
    assign sts.sq_last      = (cnt_reg == 6'(glcc_pkg::SqLast));
    assign sts.rt_last      = (cnt_reg == 6'(glcc_pkg::RtLast));
    assign sts.div_busy     = div_busy;
    assign sts.final_sample = (st != glcc_pkg::ST_CLEAR) || last;

endmodule

@@ rtl/glcc_ctrl.sv @@
// Controller: sequences the clearing pass, cell writes and line walks.
module glcc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_mode,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  glcc_pkg::sts_t  sts,
    output glcc_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SQ_A, S_SQ_B_INIT, S_SQ_B, S_RT_INIT, S_RT,
        S_K_START, S_K_WAIT, S_N1, S_QX_WAIT, S_QX, S_QY_WAIT, S_QY,
        S_CX_START, S_CX_WAIT, S_CX, S_CY_WAIT, S_CY, S_RD, S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state and operation decode.
    always_comb begin
        state_next = state_reg;
        cmd.op     = glcc_pkg::OP_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = glcc_pkg::OP_CLEAR;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_mode == glcc_pkg::MODE_WRITE) begin
                        cmd.op = glcc_pkg::OP_WRITE;
                    end else begin
                        cmd.op     = glcc_pkg::OP_LOAD;
                        state_next = S_SQ_A;
                    end
                end
            end
            S_SQ_A: begin
                cmd.op = glcc_pkg::OP_SQ;
                if (sts.sq_last) state_next = S_SQ_B_INIT;
            end
            S_SQ_B_INIT: begin
                cmd.op     = glcc_pkg::OP_SQ_B_INIT;
                state_next = S_SQ_B;
            end
            S_SQ_B: begin
                cmd.op = glcc_pkg::OP_SQ;
                if (sts.sq_last) state_next = S_RT_INIT;
            end
            S_RT_INIT: begin
                cmd.op     = glcc_pkg::OP_RT_INIT;
                state_next = S_RT;
            end
            S_RT: begin
                cmd.op = glcc_pkg::OP_RT;
                if (sts.rt_last) state_next = S_K_START;
            end
            S_K_START: begin
                cmd.op     = glcc_pkg::OP_DIV_K;
                state_next = S_K_WAIT;
            end
            S_K_WAIT: begin
                if (!sts.div_busy) state_next = S_N1;
            end
            S_N1: begin
                cmd.op     = glcc_pkg::OP_N1;
                state_next = S_QX_WAIT;
            end
            S_QX_WAIT: begin
                if (!sts.div_busy) state_next = S_QX;
            end
            S_QX: begin
                cmd.op     = glcc_pkg::OP_QX;
                state_next = S_QY_WAIT;
            end
            S_QY_WAIT: begin
                if (!sts.div_busy) state_next = S_QY;
            end
            S_QY: begin
                cmd.op     = glcc_pkg::OP_QY;
                state_next = S_CX_START;
            end
            S_CX_START: begin
                cmd.op     = glcc_pkg::OP_DIV_X;
                state_next = S_CX_WAIT;
            end
            S_CX_WAIT: begin
                if (!sts.div_busy) state_next = S_CX;
            end
            S_CX: begin
                cmd.op     = glcc_pkg::OP_CX;
                state_next = S_CY_WAIT;
            end
            S_CY_WAIT: begin
                if (!sts.div_busy) state_next = S_CY;
            end
            S_CY: begin
                cmd.op     = glcc_pkg::OP_CY;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.op     = glcc_pkg::OP_READ;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                // Results are written only once the output register is free.
                if (out_free) begin
                    cmd.op     = glcc_pkg::OP_EVAL;
                    state_next = sts.final_sample ? S_IDLE : S_CX_START;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EVAL && out_free && sts.final_sample) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/grid_line_collision_check_unit.sv @@
// Top level: stream channels, register port and the controller with its datapath.
//
// Holds an occupancy grid of MAX_SIDE x MAX_SIDE signed cost bytes and checks
// straight lines against it. Input transfers on s_axis carry either a cell
// write (tuser = 0) or a line check (tuser = 1). A cell write gives no
// result. A line check gives exactly one result transfer on the m_axis
// channel: the first failing sample and its cost, or a clear status.
// The sum of squares and the square root are done one bit per cycle, and
// every division (sample count, per-axis increments, two cell coordinates
// per sample) goes through one shared divider; each sample also reads the
// grid once. After reset the grid is swept to unknown, one cell per cycle;
// s_tready stays low meanwhile while the register port works as usual. A
// finished result waits in the output register while the next item is
// accepted; a further line check waits before writing its result until
// the receiver has taken the previous one.
// Registers are to be written only while the unit is idle; the unit itself
// does not enforce this.
module grid_line_collision_check_unit #(
    parameter int MAX_SIDE = glcc_pkg::MaxSideDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] cell_index, [23:16] cell_value, [55:24] start_x, [87:56] start_y,
    // [119:88] goal_x, [151:120] goal_y
    input  logic [151:0] s_tdata,
    // [0] mode
    input  logic [0:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] hit_x, [63:32] hit_y, [71:64] hit_cost
    output logic [71:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    // Register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    glcc_pkg::cfg_t  cfg_reg;
    glcc_pkg::item_t item;
    glcc_pkg::cmd_t  cmd;
    glcc_pkg::sts_t  sts;
    glcc_pkg::reg_idx_t idx;

    logic [1:0]         res_status;
    logic signed [31:0] res_x, res_y;
    logic signed [7:0]  res_cost;

    assign idx    = glcc_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    // Register writes at the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= 7'd50;
            cfg_reg.allow_unk <= 1'b0;
            cfg_reg.cstep     <= 31'd3277;
            cfg_reg.csize     <= 31'd3277;
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.mwidth    <= 9'd256;
            cfg_reg.mheight   <= 9'd256;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                glcc_pkg::REG_THRESHOLD: cfg_reg.threshold <= pwdata[6:0];
                glcc_pkg::REG_ALLOW_UNK: cfg_reg.allow_unk <= pwdata[0];
                glcc_pkg::REG_CSTEP:     cfg_reg.cstep     <= pwdata[30:0];
                glcc_pkg::REG_CSIZE:     cfg_reg.csize     <= pwdata[30:0];
                glcc_pkg::REG_ORIGIN_X:  cfg_reg.origin_x  <= pwdata;
                glcc_pkg::REG_ORIGIN_Y:  cfg_reg.origin_y  <= pwdata;
                glcc_pkg::REG_MWIDTH:    cfg_reg.mwidth    <= pwdata[8:0];
                glcc_pkg::REG_MHEIGHT:   cfg_reg.mheight   <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (idx)
            glcc_pkg::REG_THRESHOLD: prdata = 32'(cfg_reg.threshold);
            glcc_pkg::REG_ALLOW_UNK: prdata = 32'(cfg_reg.allow_unk);
            glcc_pkg::REG_CSTEP:     prdata = 32'(cfg_reg.cstep);
            glcc_pkg::REG_CSIZE:     prdata = 32'(cfg_reg.csize);
            glcc_pkg::REG_ORIGIN_X:  prdata = cfg_reg.origin_x;
            glcc_pkg::REG_ORIGIN_Y:  prdata = cfg_reg.origin_y;
            glcc_pkg::REG_MWIDTH:    prdata = 32'(cfg_reg.mwidth);
            glcc_pkg::REG_MHEIGHT:   prdata = 32'(cfg_reg.mheight);
            default:                 prdata = '0;
        endcase
    end

    // Unpack the input transfer.
    assign item.mode       = s_tuser[0];
    assign item.cell_index = s_tdata[15:0];
    assign item.cell_value = s_tdata[23:16];
    assign item.start_x    = s_tdata[55:24];
    assign item.start_y    = s_tdata[87:56];
    assign item.goal_x     = s_tdata[119:88];
    assign item.goal_y     = s_tdata[151:120];

    glcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (item.mode),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    glcc_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .item       (item),
        .sts        (sts),
        .res_status (res_status),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_cost   (res_cost)
    );

    // Pack the result transfer.
    assign m_tdata = {res_cost, res_y, res_x};
    assign m_tuser = res_status;

endmodule

@@ tb/sv/tb_grid_line_collision_check_unit.sv @@
// Testbench for the grid line collision check unit: random and directed traffic with a scoreboard.
`timescale 1ns / 100ps

module tb_grid_line_collision_check_unit;

    localparam logic MODE_LINE = ~glcc_pkg::MODE_WRITE;
    localparam int GRID_SIDE = 256;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 300;

    // One line check outcome.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [7:0]  hit_cost;
    } hit_t;

    // Grid model, register copy and the queue of outcomes still to arrive.
    class line_check_board;
        logic signed [7:0] grid[GRID_CELLS];
        glcc_pkg::cfg_t cfg;
        hit_t pending_hits[$];
        int errors;

        function new();
            foreach (grid[i]) grid[i] = glcc_pkg::COST_UNKNOWN;
            cfg.threshold = 7'd50;
            cfg.allow_unk = 1'b0;
            cfg.cstep = 31'd3277;
            cfg.csize = 31'd3277;
            cfg.origin_x = '0;
            cfg.origin_y = '0;
            cfg.mwidth = 9'd256;
            cfg.mheight = 9'd256;
            errors = 0;
        endfunction

        function void set_reg(glcc_pkg::reg_idx_t idx, logic [31:0] v);
            case (idx)
                glcc_pkg::REG_THRESHOLD: cfg.threshold = v[6:0];
                glcc_pkg::REG_ALLOW_UNK: cfg.allow_unk = v[0];
                glcc_pkg::REG_CSTEP:     cfg.cstep = v[30:0];
                glcc_pkg::REG_CSIZE:     cfg.csize = v[30:0];
                glcc_pkg::REG_ORIGIN_X:  cfg.origin_x = v;
                glcc_pkg::REG_ORIGIN_Y:  cfg.origin_y = v;
                glcc_pkg::REG_MWIDTH:    cfg.mwidth = v[8:0];
                glcc_pkg::REG_MHEIGHT:   cfg.mheight = v[8:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff_cell_size();
            return (cfg.csize == 0) ? 64'd1 : longint'(cfg.csize);
        endfunction

        function longint unsigned eff_step();
            longint unsigned half;
            longint unsigned s;
            half = eff_cell_size() >> 1;
            s = (cfg.cstep > half) ? longint'(cfg.cstep) : half;
            return (s == 0) ? 64'd1 : s;
        endfunction

        // Smallest r with r*r >= a*a + b*b.
        function longint unsigned ceil_root(longint unsigned a, longint unsigned b);
            logic [71:0] sum;
            logic [71:0] c;
            logic [71:0] r;
            sum = 72'(a) * 72'(a) + 72'(b) * 72'(b);
            r = '0;
            for (int bit_pos = 35; bit_pos >= 0; bit_pos--) begin
                c = r | (72'd1 << bit_pos);
                if (c * c <= sum) r = c;
            end
            if (r * r != sum) r = r + 1;
            return r[63:0];
        endfunction

        function longint along(longint from, longint to, longint unsigned i,
                               longint unsigned n1);
            longint d;
            longint unsigned mag;
            longint unsigned off;
            d = to - from;
            mag = (d < 0) ? -d : d;
            off = (i * mag) / n1;
            return (d < 0) ? from - longint'(off) : from + longint'(off);
        endfunction

        function longint to_cell(longint w, longint origin, longint unsigned cs, int side);
            longint diff;
            longint unsigned c;
            diff = w - origin;
            if (diff < 0) return -1;
            c = longint'(diff) / cs;
            if (c >= side) return -1;
            return longint'(c);
        endfunction

        // Notes an accepted input transfer; a line check queues its outcome.
        function void note_item(glcc_pkg::item_t it);
            longint sx, sy, gx, gy, dx, dy, wx, wy, mx, my;
            longint unsigned cs, stp, r, k, n1;
            int wd, ht;
            hit_t h;
            logic signed [7:0] cost;
            if (it.mode == glcc_pkg::MODE_WRITE) begin
                grid[it.cell_index] = it.cell_value;
                return;
            end
            sx = it.start_x;
            sy = it.start_y;
            gx = it.goal_x;
            gy = it.goal_y;
            dx = gx - sx;
            dy = gy - sy;
            cs = eff_cell_size();
            stp = eff_step();
            wd = (cfg.mwidth > GRID_SIDE) ? GRID_SIDE : int'(cfg.mwidth);
            ht = (cfg.mheight > GRID_SIDE) ? GRID_SIDE : int'(cfg.mheight);
            r = ceil_root((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
            k = r / stp + (((r % stp) != 0) ? 1 : 0);
            n1 = (k < 1) ? 1 : k;
            h = '0;
            for (longint unsigned i = 0; i <= n1; i++) begin
                wx = along(sx, gx, i, n1);
                wy = along(sy, gy, i, n1);
                mx = to_cell(wx, longint'(cfg.origin_x), cs, wd);
                my = to_cell(wy, longint'(cfg.origin_y), cs, ht);
                if (mx < 0 || my < 0) begin
                    h.status = glcc_pkg::ST_OUT;
                    cost = glcc_pkg::COST_OUT;
                end else begin
                    cost = grid[(my * wd + mx) % GRID_CELLS];
                    if (cost == glcc_pkg::COST_UNKNOWN && !cfg.allow_unk)
                        h.status = glcc_pkg::ST_UNKNOWN;
                    else if (int'(cost) >= int'(cfg.threshold))
                        h.status = glcc_pkg::ST_BLOCKED;
                end
                if (h.status != glcc_pkg::ST_CLEAR) begin
                    h.hit_x = wx[31:0];
                    h.hit_y = wy[31:0];
                    h.hit_cost = cost;
                    break;
                end
            end
            pending_hits = {pending_hits, h};
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one accepted result transfer with the oldest outcome.
        task check_result(logic [1:0] status, logic [71:0] data);
            hit_t exp_hit;
            if (pending_hits.size() == 0) begin
                report($sformatf("unexpected result status %0d data %h", status, data));
                return;
            end
            exp_hit = pending_hits.pop_front();
            if (status != exp_hit.status)
                report($sformatf("status %0d, expected %0d", status, exp_hit.status));
            if (data[31:0] != exp_hit.hit_x)
                report($sformatf("hit_x %h, expected %h", data[31:0], exp_hit.hit_x));
            if (data[63:32] != exp_hit.hit_y)
                report($sformatf("hit_y %h, expected %h", data[63:32], exp_hit.hit_y));
            if (data[71:64] != exp_hit.hit_cost)
                report($sformatf("hit_cost %0d, expected %0d", $signed(data[71:64]),
                                 exp_hit.hit_cost));
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    line_check_board board;
    longint cycles = 0;
    bit no_idle;

    grid_line_collision_check_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Monitors: note input transfers and check result transfers.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            board.note_item(glcc_pkg::item_t'({s_tuser[0], s_tdata[15:0], s_tdata[23:16],
                s_tdata[55:24], s_tdata[87:56], s_tdata[119:88], s_tdata[151:120]}));
        end
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
    end

    // Receiver with random stalls.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic reg_write(glcc_pkg::reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(glcc_pkg::item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {it.goal_y, it.goal_x, it.start_y, it.start_x, it.cell_value,
                    it.cell_index};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the sender until every outstanding result is in and the unit is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic longint unsigned rnd_upto(longint unsigned m);
        longint unsigned v;
        v = {$urandom, $urandom};
        return (m == 64'hFFFF_FFFF_FFFF_FFFF) ? v : v % (m + 1);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic glcc_pkg::item_t write_item(logic [15:0] idx, logic signed [7:0] v);
        glcc_pkg::item_t it;
        it = '0;
        it.mode = glcc_pkg::MODE_WRITE;
        it.cell_index = idx;
        it.cell_value = v;
        return it;
    endfunction

    function automatic glcc_pkg::item_t line_item(logic [31:0] sx, logic [31:0] sy,
                                                  logic [31:0] gx, logic [31:0] gy);
        glcc_pkg::item_t it;
        it = '0;
        it.mode = MODE_LINE;
        it.start_x = sx;
        it.start_y = sy;
        it.goal_x = gx;
        it.goal_y = gy;
        it.cell_index = 16'($urandom);
        it.cell_value = 8'($urandom);
        return it;
    endfunction

    // Random cell write, mostly inside the map in use.
    function automatic glcc_pkg::item_t random_write();
        int wd, ht;
        logic [15:0] idx;
        logic signed [7:0] v;
        wd = (board.cfg.mwidth > GRID_SIDE) ? GRID_SIDE : int'(board.cfg.mwidth);
        ht = (board.cfg.mheight > GRID_SIDE) ? GRID_SIDE : int'(board.cfg.mheight);
        if (wd == 0 || ht == 0 || $urandom_range(0, 4) == 0) idx = 16'($urandom);
        else idx = 16'($urandom_range(0, ht - 1) * wd + $urandom_range(0, wd - 1));
        case ($urandom_range(0, 5))
            0: v = glcc_pkg::COST_UNKNOWN;
            1: v = 8'(board.cfg.threshold);
            2: v = 8'(board.cfg.threshold) - 8'd1;
            3: v = 8'($urandom);
            4: v = 8'sd100;
            default: v = 8'($urandom_range(0, 100));
        endcase
        return write_item(idx, v);
    endfunction

    // Random line check: short walks that mostly start near or inside the map.
    function automatic glcc_pkg::item_t random_line();
        longint unsigned ext_x, ext_y, stp;
        longint sx, sy, gx, gy, dx, dy;
        stp = board.eff_step();
        ext_x = board.eff_cell_size() * ((board.cfg.mwidth > GRID_SIDE) ? GRID_SIDE
                                          : board.cfg.mwidth);
        ext_y = board.eff_cell_size() * ((board.cfg.mheight > GRID_SIDE) ? GRID_SIDE
                                          : board.cfg.mheight);
        if ($urandom_range(0, 9) == 0) begin
            sx = longint'($signed($urandom));
            sy = longint'($signed($urandom));
        end else begin
            sx = longint'(board.cfg.origin_x) - longint'(ext_x / 8)
                 + longint'(rnd_upto(ext_x + ext_x / 4));
            sy = longint'(board.cfg.origin_y) - longint'(ext_y / 8)
                 + longint'(rnd_upto(ext_y + ext_y / 4));
        end
        dx = ($urandom_range(0, 4) == 0) ? 0 : longint'(rnd_upto(stp * 12));
        dy = ($urandom_range(0, 4) == 0) ? 0 : longint'(rnd_upto(stp * 12));
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        sx = longint'($signed(clamp32(sx)));
        sy = longint'($signed(clamp32(sy)));
        gx = sx + dx;
        gy = sy + dy;
        return line_item(sx[31:0], sy[31:0], clamp32(gx), clamp32(gy));
    endfunction

    task automatic load_config(int thr, int unk, logic [31:0] cstep, logic [31:0] csize,
                               logic [31:0] ox, logic [31:0] oy, int wd, int ht);
        reg_write(glcc_pkg::REG_THRESHOLD, thr);
        reg_write(glcc_pkg::REG_ALLOW_UNK, unk);
        reg_write(glcc_pkg::REG_CSTEP, cstep);
        reg_write(glcc_pkg::REG_CSIZE, csize);
        reg_write(glcc_pkg::REG_ORIGIN_X, ox);
        reg_write(glcc_pkg::REG_ORIGIN_Y, oy);
        reg_write(glcc_pkg::REG_MWIDTH, wd);
        reg_write(glcc_pkg::REG_MHEIGHT, ht);
    endtask

    task automatic random_phase();
        no_idle = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n < 25 || $urandom_range(0, 1)) send_item(random_write());
            else send_item(random_line());
        end
        drain();
    endtask

    // Stimulus sequence.
    initial begin
        logic [31:0] cs;
        board = new();
        no_idle = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset settings: threshold edges, odd costs, extremes.
        send_item(write_item(16'd0, 8'sd100));
        send_item(write_item(16'd1, 8'sd49));
        send_item(write_item(16'd2, 8'sd50));
        send_item(write_item(16'd3, -8'sd128));
        send_item(write_item(16'd257, 8'sd127));
        send_item(write_item(16'hFFFF, 8'sd0));
        send_item(line_item(32'd0, 32'd0, 32'd0, 32'd0));
        send_item(line_item(32'd3377, 32'd100, 32'd9931, 32'd100));
        send_item(line_item(32'd9931, 32'd100, 32'd9931, 32'd100));
        send_item(line_item(32'd9931, 32'd100, 32'd9931, 32'd30000));
        send_item(line_item(-32'sd5, 32'd100, 32'd100, 32'd100));
        send_item(line_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(line_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_item(line_item(32'd3377, 32'd3377, 32'd3377, 32'd3377));
        send_item(line_item(32'd838000, 32'd838000, 32'd838000, 32'd838000));
        send_item(line_item(32'd838912, 32'd100, 32'd838912, 32'd100));
        drain();

        // Unknown cells let through; unit cells; offset map.
        load_config(60, 1, 32'd65536, 32'd65536, -32'sd327680, 32'd196608, 16, 12);
        random_phase();
        // Zero step request and the lowest threshold.
        load_config(0, 0, 32'd0, 32'd2, 32'd0, 32'd0, 8, 8);
        random_phase();
        // Largest step and cell, lowest origin, full map, highest threshold code.
        load_config(127, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    256, 256);
        random_phase();
        // Zero cell size, empty width and oversized height.
        load_config(101, 0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 0, 511);
        random_phase();
        // Oversized width saturates to the full grid.
        load_config(1, 1, 32'd3, 32'd8, -32'sd100, -32'sd100, 511, 3);
        random_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            cs = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                 : $urandom_range(1, 32'h0004_0000);
            load_config($urandom_range(0, 101), $urandom_range(0, 1),
                        $urandom_range(0, 1) ? $urandom_range(0, cs) : $urandom,
                        cs, $urandom, $urandom,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(1, 48),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(1, 48));
            random_phase();
        end

        // All stimulus accepted: wait for stragglers, then judge.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        foreach (board.pending_hits[i])
            board.report($sformatf("result with status %0d never arrived",
                                   board.pending_hits[i].status));
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
